// File: rtl/cvxhull_pkg.sv
// ----------------------------------------------------------------------------
// cvxhull_pkg
// Shared types for the monotone chain convex hull block.
// ----------------------------------------------------------------------------
package cvxhull_pkg;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_VSTART = 14'b00000000000100,
    S_LATC   = 14'b00000000001000,
    S_TEST   = 14'b00000000010000,
    S_RDPT   = 14'b00000000100000,
    S_DIFF   = 14'b00000001000000,
    S_MUL1   = 14'b00000010000000,
    S_MUL2   = 14'b00000100000000,
    S_CMP    = 14'b00001000000000,
    S_PUSH   = 14'b00010000000000,
    S_EMRD   = 14'b00100000000000,
    S_EMWAIT = 14'b01000000000000,
    S_EMOUT  = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic latch_c;
    logic diff;
    logic mul1;
    logic mul2;
  } cross_ctl_t;

endpackage

// File: rtl/cvxhull_point_if.sv
// ----------------------------------------------------------------------------
// cvxhull_point_if
// Point request channel: coordinates and end-of-set mark.
// ----------------------------------------------------------------------------
interface cvxhull_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// File: rtl/cvxhull_hull_if.sv
// ----------------------------------------------------------------------------
// cvxhull_hull_if
// Hull result channel: vertex index and loop-closing mark.
// ----------------------------------------------------------------------------
interface cvxhull_hull_if #(
  parameter int IDX_W = 5
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] hull_index;
  logic             hull_last;

  modport source (output valid, output hull_index, output hull_last, input ready);
  modport sink   (input valid, input hull_index, input hull_last, output ready);
endinterface

// File: rtl/cvxhull_point_store.sv
// ----------------------------------------------------------------------------
// cvxhull_point_store
// Point memory, one write and two registered read ports.
// ----------------------------------------------------------------------------
module cvxhull_point_store #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/cvxhull_stack.sv
// ----------------------------------------------------------------------------
// cvxhull_stack
// Hull index stack memory, one write and two registered read ports.
// ----------------------------------------------------------------------------
module cvxhull_stack #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 5,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/cvxhull_cross.sv
// ----------------------------------------------------------------------------
// cvxhull_cross
// Cross product sign unit: one shared multiplier, two passes, then compare.
// ----------------------------------------------------------------------------
module cvxhull_cross #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  cvxhull_pkg::cross_ctl_t      ctl_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  output logic                         gt_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] c_x_q, c_y_q;
  logic signed [DW-1:0]         dxt_q, dyt_q, dxc_q, dyc_q;
  logic signed [DW-1:0]         mul_a, mul_b;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         p1_q, p2_q;

  // a = second (s), b = top (t), c latched earlier from port a
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_c) begin
      c_x_q <= a_x_i;
      c_y_q <= a_y_i;
    end
    if (ctl_i.diff) begin
      dxt_q <= DW'(b_x_i) - DW'(a_x_i);
      dyt_q <= DW'(b_y_i) - DW'(a_y_i);
      dxc_q <= DW'(c_x_q) - DW'(a_x_i);
      dyc_q <= DW'(c_y_q) - DW'(a_y_i);
    end
    if (ctl_i.mul1) begin
      p1_q <= prod;
    end
    if (ctl_i.mul2) begin
      p2_q <= prod;
    end
  end

  assign mul_a = ctl_i.mul2 ? dyt_q : dxt_q;
  assign mul_b = ctl_i.mul2 ? dxc_q : dyc_q;
  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign gt_o  = p1_q > p2_q;

endmodule

// File: rtl/cvxhull_ctrl.sv
// ----------------------------------------------------------------------------
// cvxhull_ctrl
// Sequencer: point loading, forward and backward chain passes, hull output.
// ----------------------------------------------------------------------------
module cvxhull_ctrl #(
  parameter int MAX_POINTS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [$clog2(MAX_POINTS)-1:0]   out_index_o,
  output logic                            out_last_o,
  output logic                            pt_we_o,
  output logic [$clog2(MAX_POINTS)-1:0]   pt_waddr_o,
  output logic [$clog2(MAX_POINTS)-1:0]   pt_raddr_a_o,
  output logic [$clog2(MAX_POINTS)-1:0]   pt_raddr_b_o,
  output logic                            stk_we_o,
  output logic [$clog2(2*MAX_POINTS)-1:0] stk_waddr_o,
  output logic [$clog2(MAX_POINTS)-1:0]   stk_wdata_o,
  output logic [$clog2(2*MAX_POINTS)-1:0] stk_raddr_a_o,
  output logic [$clog2(2*MAX_POINTS)-1:0] stk_raddr_b_o,
  input  logic [$clog2(MAX_POINTS)-1:0]   stk_rdata_a_i,
  input  logic [$clog2(MAX_POINTS)-1:0]   stk_rdata_b_i,
  output cvxhull_pkg::cross_ctl_t         cross_ctl_o,
  input  logic                            cross_gt_i
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SA_W  = $clog2(2 * MAX_POINTS);
  localparam int DPW   = $clog2(2 * MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MaxCnt   = CNT_W'(MAX_POINTS);
  localparam logic [DPW-1:0]   StkDepth = DPW'(2 * MAX_POINTS);

  cvxhull_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DPW-1:0]   depth_q, depth_d, floor_q, floor_d, push_depth, limit;
  logic [IDX_W-1:0] v_q, v_d;
  logic             bwd_q, bwd_d;
  logic [SA_W-1:0]  k_q, k_d;
  logic             out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [IDX_W-1:0] out_index_q, out_index_d;
  logic [DPW-1:0]   depth_m1, depth_m2;
  logic [CNT_W-1:0] cnt_m2;

  assign push_depth = (depth_q < StkDepth) ? depth_q + DPW'(1) : depth_q;
  assign limit      = bwd_q ? floor_q : DPW'(1);
  assign depth_m1   = depth_q - DPW'(1);
  assign depth_m2   = depth_q - DPW'(2);
  assign cnt_m2     = cnt_q - CNT_W'(2);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    depth_d       = depth_q;
    floor_d       = floor_q;
    v_d           = v_q;
    bwd_d         = bwd_q;
    k_d           = k_q;
    out_valid_d   = out_valid_q;
    out_last_d    = out_last_q;
    out_index_d   = out_index_q;
    in_ready_o    = 1'b0;
    pt_we_o       = 1'b0;
    pt_waddr_o    = cnt_q[IDX_W-1:0];
    pt_raddr_a_o  = stk_rdata_a_i;
    pt_raddr_b_o  = stk_rdata_b_i;
    stk_we_o      = 1'b0;
    stk_waddr_o   = depth_q[SA_W-1:0];
    stk_wdata_o   = v_q;
    stk_raddr_a_o = depth_m2[SA_W-1:0];
    stk_raddr_b_o = depth_m1[SA_W-1:0];
    cross_ctl_o   = '0;

    unique case (state_q)
      cvxhull_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < MaxCnt) begin
            pt_we_o = 1'b1;
            cnt_d   = cnt_q + CNT_W'(1);
          end
          if (in_last_i) begin
            state_d = cvxhull_pkg::S_INIT;
          end
        end
      end
      cvxhull_pkg::S_INIT: begin
        stk_we_o    = 1'b1;
        stk_waddr_o = '0;
        stk_wdata_o = '0;
        depth_d     = DPW'(1);
        bwd_d       = 1'b0;
        k_d         = '0;
        if (cnt_q >= CNT_W'(2)) begin
          v_d     = IDX_W'(1);
          state_d = cvxhull_pkg::S_VSTART;
        end else begin
          state_d = cvxhull_pkg::S_EMRD;
        end
      end
      cvxhull_pkg::S_VSTART: begin
        pt_raddr_a_o = v_q;
        state_d      = cvxhull_pkg::S_LATC;
      end
      cvxhull_pkg::S_LATC: begin
        cross_ctl_o.latch_c = 1'b1;
        state_d             = cvxhull_pkg::S_TEST;
      end
      cvxhull_pkg::S_TEST: begin
        if (depth_q > limit) begin
          state_d = cvxhull_pkg::S_RDPT;
        end else begin
          state_d = cvxhull_pkg::S_PUSH;
        end
      end
      cvxhull_pkg::S_RDPT: begin
        state_d = cvxhull_pkg::S_DIFF;
      end
      cvxhull_pkg::S_DIFF: begin
        cross_ctl_o.diff = 1'b1;
        state_d          = cvxhull_pkg::S_MUL1;
      end
      cvxhull_pkg::S_MUL1: begin
        cross_ctl_o.mul1 = 1'b1;
        state_d          = cvxhull_pkg::S_MUL2;
      end
      cvxhull_pkg::S_MUL2: begin
        cross_ctl_o.mul2 = 1'b1;
        state_d          = cvxhull_pkg::S_CMP;
      end
      cvxhull_pkg::S_CMP: begin
        if (cross_gt_i) begin
          depth_d = depth_m1;
          state_d = cvxhull_pkg::S_TEST;
        end else begin
          state_d = cvxhull_pkg::S_PUSH;
        end
      end
      cvxhull_pkg::S_PUSH: begin
        stk_we_o = depth_q < StkDepth;
        depth_d  = push_depth;
        state_d  = cvxhull_pkg::S_VSTART;
        if (!bwd_q) begin
          if (CNT_W'(v_q) + CNT_W'(1) == cnt_q) begin
            floor_d = push_depth;
            bwd_d   = 1'b1;
            v_d     = cnt_m2[IDX_W-1:0];
          end else begin
            v_d = v_q + IDX_W'(1);
          end
        end else if (v_q == '0) begin
          k_d     = '0;
          state_d = cvxhull_pkg::S_EMRD;
        end else begin
          v_d = v_q - IDX_W'(1);
        end
      end
      cvxhull_pkg::S_EMRD: begin
        stk_raddr_a_o = k_q;
        state_d       = cvxhull_pkg::S_EMWAIT;
      end
      cvxhull_pkg::S_EMWAIT: begin
        out_valid_d = 1'b1;
        out_index_d = stk_rdata_a_i;
        out_last_d  = DPW'(k_q) + DPW'(1) == depth_q;
        state_d     = cvxhull_pkg::S_EMOUT;
      end
      cvxhull_pkg::S_EMOUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            depth_d = '0;
            state_d = cvxhull_pkg::S_IDLE;
          end else begin
            k_d     = k_q + SA_W'(1);
            state_d = cvxhull_pkg::S_EMRD;
          end
        end
      end
      default: begin
        state_d = cvxhull_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvxhull_pkg::S_IDLE;
      cnt_q       <= '0;
      depth_q     <= '0;
      floor_q     <= '0;
      v_q         <= '0;
      bwd_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      depth_q     <= depth_d;
      floor_q     <= floor_d;
      v_q         <= v_d;
      bwd_q       <= bwd_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

endmodule

// File: rtl/convex_hull_monotone_chain_top.sv
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain_top
// Convex hull of a sorted point set by the monotone chain method.
// ----------------------------------------------------------------------------
// Usage:
//   point_i takes one point request per cycle while the block is loading,
//   sorted by x then y; points beyond MAX_POINTS are dropped. The request
//   marked last_point starts the hull: a forward chain pass, then a backward
//   pass that never pops below the forward chain's end. Collinear boundary
//   points are kept.
//   hull_o then gives the hull as a closed loop of load-order indices from
//   index 0 back to index 0, hull_last set on the closing one.
//   Hull: an init step; each chain step reads and latches the new point, and
//   each cross product test reads the stack points, forms the differences,
//   makes two passes of the one shared multiplier and compares, then pops or
//   pushes. Each output reads the stack and registers the result. point_i is
//   not ready from the last point until the closing result is taken.
//   A stalled receiver holds the current result in the output register.
//   Reset empties the point set; no clearing pass is needed.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain_top #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cvxhull_point_if.sink         point_i,
  cvxhull_hull_if.source        hull_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int SA_W  = $clog2(2 * MAX_POINTS);
  localparam int PT_W  = 2 * COORD_BITS;

  logic                         pt_we;
  logic [IDX_W-1:0]             pt_waddr, pt_raddr_a, pt_raddr_b;
  logic [PT_W-1:0]              pt_rdata_a, pt_rdata_b;
  logic                         stk_we;
  logic [SA_W-1:0]              stk_waddr, stk_raddr_a, stk_raddr_b;
  logic [IDX_W-1:0]             stk_wdata, stk_rdata_a, stk_rdata_b;
  cvxhull_pkg::cross_ctl_t      cross_ctl;
  logic                         cross_gt;

  cvxhull_point_store #(
    .DEPTH  (MAX_POINTS),
    .WIDTH  (PT_W),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (pt_we),
    .waddr_i   (pt_waddr),
    .wdata_i   ({point_i.point_x, point_i.point_y}),
    .raddr_a_i (pt_raddr_a),
    .raddr_b_i (pt_raddr_b),
    .rdata_a_o (pt_rdata_a),
    .rdata_b_o (pt_rdata_b)
  );

  cvxhull_stack #(
    .DEPTH  (2 * MAX_POINTS),
    .WIDTH  (IDX_W),
    .ADDR_W (SA_W)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (stk_we),
    .waddr_i   (stk_waddr),
    .wdata_i   (stk_wdata),
    .raddr_a_i (stk_raddr_a),
    .raddr_b_i (stk_raddr_b),
    .rdata_a_o (stk_rdata_a),
    .rdata_b_o (stk_rdata_b)
  );

  cvxhull_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk_i (clk_i),
    .ctl_i (cross_ctl),
    .a_x_i (pt_rdata_a[PT_W-1:COORD_BITS]),
    .a_y_i (pt_rdata_a[COORD_BITS-1:0]),
    .b_x_i (pt_rdata_b[PT_W-1:COORD_BITS]),
    .b_y_i (pt_rdata_b[COORD_BITS-1:0]),
    .gt_o  (cross_gt)
  );

  cvxhull_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (point_i.valid),
    .in_ready_o    (point_i.ready),
    .in_last_i     (point_i.last_point),
    .out_valid_o   (hull_o.valid),
    .out_ready_i   (hull_o.ready),
    .out_index_o   (hull_o.hull_index),
    .out_last_o    (hull_o.hull_last),
    .pt_we_o       (pt_we),
    .pt_waddr_o    (pt_waddr),
    .pt_raddr_a_o  (pt_raddr_a),
    .pt_raddr_b_o  (pt_raddr_b),
    .stk_we_o      (stk_we),
    .stk_waddr_o   (stk_waddr),
    .stk_wdata_o   (stk_wdata),
    .stk_raddr_a_o (stk_raddr_a),
    .stk_raddr_b_o (stk_raddr_b),
    .stk_rdata_a_i (stk_rdata_a),
    .stk_rdata_b_i (stk_rdata_b),
    .cross_ctl_o   (cross_ctl),
    .cross_gt_i    (cross_gt)
  );

endmodule
